### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks used by neighbor_difference_edge_map
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ON_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/nde_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nde_pkg
// types, constants and helpers of the neighbor difference edge map
// ---------------------------------------------------------------------------
package nde_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int DIM_W   = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W = 10;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CNT_W   = DIM_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  localparam logic [PIX_W-1:0] COLOR_WHITE = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] COLOR_BLACK = 24'h000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // frame border flags of the pixel a result belongs to
  typedef struct packed {
    logic col_first;
    logic col_last;
    logic row_first;
    logic row_last;
  } border_t;

  // one push through the line store pipeline
  typedef struct packed {
    logic              push;
    logic              emit;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  px;
    border_t           border;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } push_t;

  typedef struct packed {
    logic               edge_res;
    logic               frame_end;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // any channel of the neighbor differs from the center by more than thr
  function automatic logic differs(input logic [PIX_W-1:0] c,
                                   input logic [PIX_W-1:0] n,
                                   input logic [CHAN_W-1:0] thr);
    logic hit;
    hit = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      if (abs_diff(c[ch*CHAN_W +: CHAN_W], n[ch*CHAN_W +: CHAN_W]) > thr) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### src/neighbor_difference_edge_map.sv
`timescale 1ns / 1ps
// a result passes the store and compare stages and the result queue after the
//   request that completes its window, one row plus one pixel after the pixel itself
// throughput: one pixel request per cycle while in_stall_o is low, set by the single
//   line store port pair; a drain request pushes fillers, one filler push per cycle
//   while the result queue has room
// reset clears counters, window and result queue at once; the line store is not
//   cleared and needs no clearing pass
// ---------------------------------------------------------------------------
// neighbor_difference_edge_map
// 3x3 neighbor color difference edge detector over a raster pixel stream
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module neighbor_difference_edge_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [nde_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nde_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [nde_pkg::CHAN_W-1:0]    red_i,
  input  logic [nde_pkg::CHAN_W-1:0]    green_i,
  input  logic [nde_pkg::CHAN_W-1:0]    blue_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          edge_res_o,
  output logic [nde_pkg::PIX_W-1:0]     out_pixel_o,
  output logic [nde_pkg::COORD_W-1:0]   out_row_o,
  output logic [nde_pkg::COORD_W-1:0]   out_col_o,
  output logic                          frame_end_o
);

  // configuration registers, width and height kept already clamped
  logic [nde_pkg::CHAN_W-1:0] thr_q;
  logic [nde_pkg::DIM_W-1:0]  img_w_q;
  logic [nde_pkg::DIM_W-1:0]  img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      img_w_q <= nde_pkg::MAX_W_DIM;
      img_h_q <= nde_pkg::MAX_H_DIM;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nde_pkg::CFG_THRESHOLD: thr_q <= cfg_data_i[nde_pkg::CHAN_W-1:0];
        nde_pkg::CFG_WIDTH:
          img_w_q <= nde_pkg::clamp_dim(cfg_data_i, nde_pkg::MAX_W_DIM);
        nde_pkg::CFG_HEIGHT:
          img_h_q <= nde_pkg::clamp_dim(cfg_data_i, nde_pkg::MAX_H_DIM);
        default: ;
      endcase
    end
  end

  // control state
  nde_pkg::state_e               state_q, state_d;
  logic [nde_pkg::ADDR_W-1:0]    ptr_q, ptr_d;       // line store push pointer
  logic [nde_pkg::CNT_W-1:0]     lag_q, lag_d;       // pushes not yet matched by results
  logic [nde_pkg::CNT_W-1:0]     pend_q, pend_d;     // pixels whose result is outstanding
  logic [nde_pkg::ROW_W-1:0]     res_row_q, res_row_d;
  logic [nde_pkg::COL_W-1:0]     res_col_q, res_col_d;

  // result queue bookkeeping
  logic [nde_pkg::FIFO_AW:0]     fifo_cnt_q;
  logic [nde_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [nde_pkg::FIFO_AW:0]     slots;

  nde_pkg::push_t                sta;                // push being issued this cycle
  nde_pkg::push_t                stb_q;              // push with store data arriving
  nde_pkg::push_t                stc_q;              // push whose window is complete

  logic                          accept;
  logic                          is_pix;
  logic                          is_drain;
  logic [nde_pkg::DIM_W-1:0]     addr_inc;
  logic [nde_pkg::DIM_W-1:0]     col_inc;
  logic [nde_pkg::DIM_W-1:0]     row_inc;
  logic                          pop;

  // slots count results already queued plus those still in the pipeline
  assign slots = fifo_cnt_q + (nde_pkg::FIFO_AW+1)'(stb_q.emit)
                            + (nde_pkg::FIFO_AW+1)'(stc_q.emit);

  // a drain in progress holds the input; otherwise only a full queue, counting results in flight, does
  assign in_stall_o = (state_q != nde_pkg::ST_RUN) ||
                      (slots >= (nde_pkg::FIFO_AW+1)'(nde_pkg::FIFO_DEPTH));
  assign accept   = in_valid_i && !in_stall_o;
  assign is_pix   = accept && (command_i == nde_pkg::CMD_PIXEL);
  assign is_drain = accept && (command_i == nde_pkg::CMD_DRAIN);

  // issue stage: address, emit decision and result coordinates
  always_comb begin
    sta      = '0;
    addr_inc = '0;
    col_inc  = '0;
    row_inc  = '0;

    sta.push = is_pix || (is_drain && (pend_q != '0)) ||
               ((state_q == nde_pkg::ST_DRAIN) &&
                (slots < (nde_pkg::FIFO_AW+1)'(nde_pkg::FIFO_DEPTH)));
    // pointer may sit past a width that was just lowered
    sta.addr = (nde_pkg::DIM_W'(ptr_q) >= img_w_q) ? '0 : ptr_q;
    sta.px   = is_pix ? {red_i, green_i, blue_i} : '0;
    // window complete once lag reaches width + 2 after this push
    sta.emit = sta.push && (lag_q > img_w_q);

    col_inc = nde_pkg::DIM_W'(res_col_q) + nde_pkg::DIM_W'(1);
    row_inc = nde_pkg::DIM_W'(res_row_q) + nde_pkg::DIM_W'(1);
    sta.border.col_first = (res_col_q == '0);
    sta.border.col_last  = (col_inc >= img_w_q);
    sta.border.row_first = (res_row_q == '0);
    sta.border.row_last  = (row_inc >= img_h_q);
    sta.row = res_row_q;
    sta.col = res_col_q;

    addr_inc = nde_pkg::DIM_W'(sta.addr) + nde_pkg::DIM_W'(1);
  end

  // counter next values
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    lag_d     = lag_q;
    pend_d    = pend_q;
    res_row_d = res_row_q;
    res_col_d = res_col_q;

    if (sta.push) begin
      ptr_d  = (addr_inc >= img_w_q) ? '0 : sta.addr + nde_pkg::ADDR_W'(1);
      pend_d = pend_q + nde_pkg::CNT_W'(is_pix) - nde_pkg::CNT_W'(sta.emit);
      if (sta.emit) begin
        // last outstanding result restarts the lag count
        lag_d = (pend_d == '0) ? '0 : lag_q;
      end else begin
        lag_d = lag_q + nde_pkg::CNT_W'(1);
      end
    end

    if (sta.emit) begin
      if (sta.border.col_last) begin
        res_col_d = '0;
        res_row_d = sta.border.row_last ? '0 : res_row_q + nde_pkg::ROW_W'(1);
      end else begin
        res_col_d = res_col_q + nde_pkg::COL_W'(1);
      end
    end

    unique case (state_q)
      nde_pkg::ST_RUN: begin
        // a drain that cannot finish in one push keeps pushing fillers
        if (is_drain && sta.push && !sta.emit) begin
          state_d = nde_pkg::ST_DRAIN;
        end
      end
      nde_pkg::ST_DRAIN: begin
        if (sta.emit) begin
          state_d = nde_pkg::ST_RUN;
        end
      end
      default: state_d = nde_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nde_pkg::ST_RUN;
      ptr_q     <= '0;
      lag_q     <= '0;
      pend_q    <= '0;
      res_row_q <= '0;
      res_col_q <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      lag_q     <= lag_d;
      pend_q    <= pend_d;
      res_row_q <= res_row_d;
      res_col_q <= res_col_d;
    end
  end

  // line store: upper row in the high half, middle row in the low half
  logic [2*nde_pkg::PIX_W-1:0] line_mem [nde_pkg::MAX_WIDTH];
  logic [2*nde_pkg::PIX_W-1:0] rd_q;
  logic [2*nde_pkg::PIX_W-1:0] fwd_data_q;
  logic                        fwd_q;
  logic [2*nde_pkg::PIX_W-1:0] col_data;
  logic [nde_pkg::PIX_W-1:0]   up_px;
  logic [nde_pkg::PIX_W-1:0]   mid_px;

  // read returns the old entry when written in the same cycle, so
  // back to back pushes to one entry (width one) take the written value
  assign col_data = fwd_q ? fwd_data_q : rd_q;
  assign up_px    = col_data[2*nde_pkg::PIX_W-1:nde_pkg::PIX_W];
  assign mid_px   = col_data[nde_pkg::PIX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (sta.push) begin
      rd_q <= line_mem[sta.addr];
    end
    if (stb_q.push) begin
      line_mem[stb_q.addr] <= {mid_px, stb_q.px};
    end
    fwd_data_q <= {mid_px, stb_q.px};
  end

  // 3x3 window, index 3*column + row, column 2 newest
  logic [nde_pkg::PIX_W-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_q <= '0;
      stc_q <= '0;
      fwd_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      stb_q <= sta;
      stc_q <= stb_q;
      fwd_q <= sta.push && stb_q.push && (sta.addr == stb_q.addr);
      if (stb_q.push) begin
        for (int i = 0; i < 6; i++) begin
          win_q[i] <= win_q[i+3];
        end
        win_q[6] <= up_px;
        win_q[7] <= mid_px;
        win_q[8] <= stb_q.px;
      end
    end
  end

  // compare stage: neighbors outside the frame are masked
  logic edge_c;

  always_comb begin
    logic skip;
    edge_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        skip = ((k == 0) && stc_q.border.col_first) ||
               ((k == 2) && stc_q.border.col_last)  ||
               ((j == 0) && stc_q.border.row_first) ||
               ((j == 2) && stc_q.border.row_last);
        if (!skip && nde_pkg::differs(win_q[4], win_q[3*k+j], thr_q)) begin
          edge_c = 1'b1;
        end
      end
    end
  end

  // result queue
  nde_pkg::res_t fifo_q [nde_pkg::FIFO_DEPTH];
  nde_pkg::res_t head;

  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (stc_q.emit) begin
      fifo_q[wr_ptr_q] <= '{edge_res:  edge_c,
                            frame_end: stc_q.border.row_last && stc_q.border.col_last,
                            row:       nde_pkg::COORD_W'(stc_q.row),
                            col:       nde_pkg::COORD_W'(stc_q.col)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
    end else begin
      if (stc_q.emit) begin
        wr_ptr_q <= wr_ptr_q + nde_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + nde_pkg::FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (nde_pkg::FIFO_AW+1)'(stc_q.emit)
                               - (nde_pkg::FIFO_AW+1)'(pop);
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = (fifo_cnt_q != '0);
  assign edge_res_o  = head.edge_res;
  assign out_pixel_o = head.edge_res ? nde_pkg::COLOR_BLACK : nde_pkg::COLOR_WHITE;
  assign out_row_o   = head.row;
  assign out_col_o   = head.col;
  assign frame_end_o = head.frame_end;

  // queued plus in-flight results never exceed the queue
  `ASSERT_ON_CLK(a_slots_bound, slots <= (nde_pkg::FIFO_AW+1)'(nde_pkg::FIFO_DEPTH))
  // every outstanding pixel is also counted in the lag
  `ASSERT_ON_CLK(a_pend_le_lag, pend_q <= lag_q)
  // forwarding only ever replaces data of a push in flight
  `ASSERT_ON_CLK(a_fwd_push, !fwd_q || stb_q.push)
  // a finished compare shows up at the output in the next cycle
  `ASSERT_NEXT(a_emit_visible, stc_q.emit, out_valid_o)

endmodule
